// ===== rtl/core/lbr_pkg.sv =====
// Shared types and constants of the LED level and relay port block.
package lbr_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned PORT_COUNT  = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PACK_W      = 24;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned GROUP_W     = 2;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_IDLE  = 2'd3
  } req_e;

  typedef struct packed {
    req_e                 req;
    logic [GROUP_W-1:0]   group;
    logic [PACK_W-1:0]    pack;
    logic [COUNT_W-1:0]   count;
    logic [IDX_W-1:0]     ridx;
  } item_t;

  typedef struct packed {
    logic [PORT_COUNT-1:0][BYTE_W-1:0] port_bytes;
    logic [LEVEL_W-1:0]                read_level;
  } result_t;

endpackage

// ===== rtl/core/lbr_in_stage.sv =====
// Input register stage: holds one accepted item until the core takes it.
module lbr_in_stage
  import lbr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  input  logic  advance_i,
  output logic  in_stall_o,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  // Stall only while a held item cannot move on.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = in_item_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/lbr_core.sv =====
// Level store, blink phase and port bytes with the per-item update logic.
module lbr_core
  import lbr_pkg::*;
#(
  parameter int unsigned PHASE_STEPS = 7,
  parameter int unsigned GROUP_COUNT = 4,
  parameter int unsigned GROUP_WIDTH = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [STORE_DEPTH-1:0][LEVEL_W-1:0] store_q, store_d;
  logic [PORT_COUNT-1:0][BYTE_W-1:0]   port_q, port_d;
  logic [LEVEL_W-1:0]                  phase_q, phase_d;
  logic [LEVEL_W-1:0]                  phase_eff;
  logic [COUNT_W-1:0]                  cnt_clip;
  logic [BYTE_W-1:0]                   wr_bits, led0_bits, led1_bits;
  logic [LEVEL_W-1:0]                  read_level;
  logic                                group_ok;

  assign cnt_clip  = (int'(item_i.count) > GROUP_WIDTH) ? COUNT_W'(GROUP_WIDTH)
                                                         : item_i.count;
  assign group_ok  = int'(item_i.group) < GROUP_COUNT;
  // Reload the phase when it has run down to zero.
  assign phase_eff = (phase_q == '0) ? LEVEL_W'(PHASE_STEPS) : phase_q;

  always_comb begin
    wr_bits   = '0;
    led0_bits = '0;
    led1_bits = '0;
    for (int k = 0; k < GROUP_WIDTH; k++) begin
      if (k < int'(cnt_clip)) begin
        wr_bits[k] = item_i.pack[LEVEL_W*k];
      end
      led0_bits[k] = store_q[k] >= phase_eff;
      led1_bits[k] = store_q[GROUP_WIDTH + k] >= phase_eff;
    end
  end

  always_comb begin
    store_d    = store_q;
    port_d     = port_q;
    phase_d    = phase_q;
    read_level = '0;
    case (item_i.req)
      REQ_WRITE: begin
        if (group_ok) begin
          for (int k = 0; k < GROUP_WIDTH; k++) begin
            if (k < int'(cnt_clip)) begin
              store_d[IDX_W'(int'(item_i.group) * GROUP_WIDTH + k)] =
                item_i.pack[LEVEL_W*k +: LEVEL_W];
            end
          end
          port_d[item_i.group] = wr_bits;
        end
      end
      REQ_TICK: begin
        port_d[0] = led0_bits;
        port_d[1] = led1_bits;
        phase_d   = phase_eff - LEVEL_W'(1);
      end
      REQ_READ: begin
        read_level = store_q[item_i.ridx];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      port_q  <= '0;
      phase_q <= LEVEL_W'(PHASE_STEPS);
    end else if (fire_i) begin
      store_q <= store_d;
      port_q  <= port_d;
      phase_q <= phase_d;
    end
  end

  assign result_o.port_bytes = port_d;
  assign result_o.read_level = read_level;

endmodule

// ===== rtl/core/led_level_blink_relay_ports.sv =====
// Top level: input stage, level core and result register of the LED/relay port block.
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled, set by the single
// pass through the level core between the input register and the result register.
// Reset: level store and port bytes clear to zero, blink phase loads PHASE_STEPS,
// both pipeline registers come up empty.
module led_level_blink_relay_ports
  import lbr_pkg::*;
#(
  parameter int unsigned PHASE_STEPS = 7,
  parameter int unsigned GROUP_COUNT = 4,
  parameter int unsigned GROUP_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [GROUP_W-1:0]  req_type_i,
  input  logic [GROUP_W-1:0]  group_sel_i,
  input  logic [PACK_W-1:0]   level_pack_i,
  input  logic [COUNT_W-1:0]  level_count_i,
  input  logic [IDX_W-1:0]    read_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BYTE_W-1:0]   led_byte_a_o,
  output logic [BYTE_W-1:0]   led_byte_b_o,
  output logic [BYTE_W-1:0]   relay_byte_a_o,
  output logic [BYTE_W-1:0]   relay_byte_b_o,
  output logic [LEVEL_W-1:0]  read_level_o
);

  item_t   in_item, s1_item;
  logic    s1_valid;
  logic    advance;
  result_t core_result;
  result_t result_q;
  logic    out_valid_q, out_valid_d;

  // Pack the input fields into one item.
  always_comb begin
    in_item.req   = req_e'(req_type_i);
    in_item.group = group_sel_i;
    in_item.pack  = level_pack_i;
    in_item.count = level_count_i;
    in_item.ridx  = read_index_i;
  end

  // Move the held item into the result register whenever that slot is free
  // or its result is being taken in this cycle; the state updates on the same edge.
  assign advance = s1_valid && (!out_valid_q || !out_stall_i);

  lbr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .in_stall_o (in_stall_o),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  lbr_core #(
    .PHASE_STEPS (PHASE_STEPS),
    .GROUP_COUNT (GROUP_COUNT),
    .GROUP_WIDTH (GROUP_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (s1_item),
    .result_o (core_result)
  );

  // Result register: fill on advance, drop once the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= core_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_byte_a_o   = result_q.port_bytes[0];
  assign led_byte_b_o   = result_q.port_bytes[1];
  assign relay_byte_a_o = result_q.port_bytes[2];
  assign relay_byte_b_o = result_q.port_bytes[3];
  assign read_level_o   = result_q.read_level;

  // An advancing item always lands in the result register.
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  // Only a read reports a nonzero level.
  a_level_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (s1_item.req != REQ_READ) |=> result_q.read_level == '0)
    else $error("nonzero read level on a non-read item");

  // Relay bytes hold across anything but a write.
  a_relay_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && out_valid_q && (s1_item.req != REQ_WRITE) |=>
      (result_q.port_bytes[2] == $past(result_q.port_bytes[2])) &&
      (result_q.port_bytes[3] == $past(result_q.port_bytes[3])))
    else $error("relay byte changed without a write");

endmodule
